### hdl/frts_pkg.sv
// Shared constants and types for the fractional-rate tick scheduler.
package frts_pkg;

    localparam int TICK_RATE  = 32768;
    localparam int NUM_CH     = 3;
    localparam int CNT_W      = 24;

    localparam int VAL_W      = 16;
    localparam int MODE_W     = 2;
    localparam int CH_W       = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    localparam int CFG_ADDR_W = CH_W + 1;
    localparam int CFG_DATA_W = VAL_W;
    localparam int EPOCH_W    = 32;
    localparam int SUB_W      = 15;

    localparam int DIV_W      = $clog2(TICK_RATE + 1);
    localparam int DCNT_W     = (DIV_W > 1) ? $clog2(DIV_W) : 1;
    localparam int SHORT_W    = (VAL_W > DIV_W) ? VAL_W : DIV_W;
    localparam int SUM_W      = ((CNT_W > SHORT_W) ? CNT_W : SHORT_W) + 2;

    localparam int S_DATA_W   = 32;
    localparam int S_USER_W   = 1;
    localparam int M_FIELDS_W = NUM_CH + 1 + EPOCH_W + SUB_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] TICK_MOD      = CNT_W'(TICK_RATE);
    localparam logic [DIV_W-1:0] TICK_DIVIDEND = DIV_W'(TICK_RATE);

    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_LAST = CFG_ADDR_W'(2 * NUM_CH - 1);

    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTERVAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RATE     = 2'd2;

    localparam logic CMD_TICK      = 1'b0;
    localparam logic CMD_SET_EPOCH = 1'b1;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

endpackage

### hdl/fractional_rate_tick_scheduler.sv
// Tick scheduler: tick counter, three Bresenham-paced channels and a seconds epoch.
//
//  channel   direction  accepted when         payload
//  s_*       in         s_tvalid & s_tready   tuser: command; tdata: epoch_value
//  m_*       out        m_tvalid & m_tready   tdata: events, second, epoch, sub-second
//  cfg_*     in         cfg_wr_en             cfg_addr register index, cfg_wdata value
//
// One item per cycle unless m_tready is low or s_tready is held low; an item
// passes the input register and its result waits in the output register until taken.
// A channel register write re-derives that channel: interval mode directly,
// rate mode through a restoring divider, one quotient bit a cycle.
// s_tready is low while a derivation is pending or in progress.
// Reset (aresetn, synchronous) gives all channels off with a period of one tick.
module fractional_rate_tick_scheduler (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [frts_pkg::S_DATA_W-1:0]      s_tdata,   // [31:0] epoch_value
    input  logic [frts_pkg::S_USER_W-1:0]      s_tuser,   // [0] command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] channel_events, [3] second_event, [35:4] epoch_seconds,
    // [50:36] sub_second_ticks, rest zero
    output logic [frts_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [frts_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [frts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int NCH  = frts_pkg::NUM_CH;
    localparam int CW   = frts_pkg::CNT_W;
    localparam int VW   = frts_pkg::VAL_W;
    localparam int SW   = frts_pkg::SHORT_W;
    localparam int DW   = frts_pkg::DIV_W;
    localparam int SMW  = frts_pkg::SUM_W;
    localparam int EW   = frts_pkg::EPOCH_W;
    localparam int M_DATA_W_L = frts_pkg::M_DATA_W;

    // configuration
    logic [frts_pkg::MODE_W-1:0] mode_reg   [NCH];
    logic [frts_pkg::MODE_W-1:0] mode_next  [NCH];
    logic [VW-1:0]               value_reg  [NCH];
    logic [VW-1:0]               value_next [NCH];
    logic [NCH-1:0]              pend_reg, pend_next;

    // divider
    frts_pkg::div_state_t        div_state_reg, div_state_next;
    logic [frts_pkg::CH_W-1:0]   div_chan_reg, div_chan_next;
    logic [VW-1:0]               div_r_reg, div_r_next;
    logic [DW-1:0]               div_q_reg, div_q_next;
    logic [VW-1:0]               div_rem_reg, div_rem_next;
    logic [frts_pkg::DCNT_W-1:0] div_cnt_reg, div_cnt_next;

    // timer state
    logic [CW-1:0]               tick_reg, tick_next;
    logic [CW-1:0]               sec_cmp_reg, sec_cmp_next;
    logic [EW-1:0]               epoch_reg, epoch_next;
    logic [CW-1:0]               cmp_reg    [NCH];
    logic [CW-1:0]               cmp_next   [NCH];
    logic [VW-1:0]               acc_reg    [NCH];
    logic [VW-1:0]               acc_next   [NCH];
    logic [SW-1:0]               short_reg  [NCH];
    logic [SW-1:0]               short_next [NCH];
    logic [VW-1:0]               err_reg    [NCH];
    logic [VW-1:0]               err_next   [NCH];
    logic [VW-1:0]               rate_reg   [NCH];
    logic [VW-1:0]               rate_next  [NCH];

    // input and output registers
    logic                        in_valid_reg, in_valid_next;
    logic                        in_cmd_reg, in_cmd_next;
    logic [EW-1:0]               in_epoch_reg, in_epoch_next;
    logic                        out_valid_reg, out_valid_next;
    logic [M_DATA_W_L-1:0]       out_data_reg, out_data_next;

    logic busy;
    logic advance;
    logic s_fire;

    assign busy     = (div_state_reg != frts_pkg::DIV_IDLE) || (|pend_reg);
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !busy && !cfg_wr_en && (!in_valid_reg || advance);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        logic                        cfg_hit;
        logic [frts_pkg::CH_W-1:0]   cfg_ch;
        logic [frts_pkg::CH_W-1:0]   pick;
        logic [VW-1:0]               pick_v;
        logic [frts_pkg::MODE_W-1:0] pick_m;
        logic [VW:0]                 trial;
        logic                        qbit;
        logic [VW-1:0]               rem_new;
        logic [DW-1:0]               q_new;
        logic [SW-1:0]               short_new;
        logic [CW-1:0]               tick_new;
        logic [CW-1:0]               sec_new;
        logic [NCH-1:0]              events;
        logic                        sec_ev;
        logic                        chan_on;
        logic [VW:0]                 acc_sum;
        logic [SW:0]                 period;
        logic [SMW-1:0]              cmp_sum;
        logic [CW-1:0]               sub_full;

        mode_next      = mode_reg;
        value_next     = value_reg;
        pend_next      = pend_reg;
        div_state_next = div_state_reg;
        div_chan_next  = div_chan_reg;
        div_r_next     = div_r_reg;
        div_q_next     = div_q_reg;
        div_rem_next   = div_rem_reg;
        div_cnt_next   = div_cnt_reg;
        tick_next      = tick_reg;
        sec_cmp_next   = sec_cmp_reg;
        epoch_next     = epoch_reg;
        cmp_next       = cmp_reg;
        acc_next       = acc_reg;
        short_next     = short_reg;
        err_next       = err_reg;
        rate_next      = rate_reg;
        in_valid_next  = in_valid_reg;
        in_cmd_next    = in_cmd_reg;
        in_epoch_next  = in_epoch_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        pick = '0;
        for (int i = NCH - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                pick = frts_pkg::CH_W'(i);
            end
        end
        pick_v = value_reg[pick];
        pick_m = mode_reg[pick];

        trial   = {div_rem_reg, frts_pkg::TICK_DIVIDEND[div_cnt_reg]};
        qbit    = (trial >= {1'b0, div_r_reg});
        rem_new = qbit ? VW'(trial - {1'b0, div_r_reg}) : trial[VW-1:0];
        q_new   = {div_q_reg[DW-2:0], qbit};
        short_new = '0;
        cmp_sum   = '0;

        // channel derivation
        unique case (div_state_reg)
            frts_pkg::DIV_IDLE: begin
                if (|pend_reg) begin
                    pend_next[pick] = 1'b0;
                    if (pick_v != '0 && pick_m == frts_pkg::MODE_RATE) begin
                        if (32'(pick_v) > 32'(frts_pkg::TICK_RATE)) begin
                            div_r_next = VW'(frts_pkg::TICK_RATE);
                        end else begin
                            div_r_next = pick_v;
                        end
                        div_q_next     = '0;
                        div_rem_next   = '0;
                        div_cnt_next   = frts_pkg::DCNT_W'(DW - 1);
                        div_chan_next  = pick;
                        div_state_next = frts_pkg::DIV_RUN;
                    end else begin
                        short_new = (pick_v == '0) ? SW'(1) : SW'(pick_v);
                        short_next[pick] = short_new;
                        err_next[pick]   = '0;
                        rate_next[pick]  = (pick_v == '0) ? VW'(1) : pick_v;
                        acc_next[pick]   = '0;
                        cmp_sum = SMW'(tick_reg) + SMW'(short_new);
                        cmp_next[pick]   = cmp_sum[CW-1:0];
                    end
                end
            end
            frts_pkg::DIV_RUN: begin
                div_q_next   = q_new;
                div_rem_next = rem_new;
                if (div_cnt_reg == '0) begin
                    short_new = SW'(q_new);
                    short_next[div_chan_reg] = short_new;
                    err_next[div_chan_reg]   = rem_new;
                    rate_next[div_chan_reg]  = div_r_reg;
                    acc_next[div_chan_reg]   = '0;
                    cmp_sum = SMW'(tick_reg) + SMW'(short_new);
                    cmp_next[div_chan_reg]   = cmp_sum[CW-1:0];
                    div_state_next = frts_pkg::DIV_IDLE;
                end else begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            default: begin
                div_state_next = frts_pkg::DIV_IDLE;
            end
        endcase

        // register write; a division in flight is dropped and redone
        cfg_hit = cfg_wr_en && (cfg_addr <= frts_pkg::CFG_ADDR_LAST);
        cfg_ch  = cfg_addr[frts_pkg::CFG_ADDR_W-1:1];
        if (cfg_hit) begin
            if (cfg_addr[0]) begin
                value_next[cfg_ch] = cfg_wdata;
            end else begin
                mode_next[cfg_ch] = cfg_wdata[frts_pkg::MODE_W-1:0];
            end
            pend_next[cfg_ch] = 1'b1;
            if (div_state_reg == frts_pkg::DIV_RUN) begin
                pend_next[div_chan_reg] = 1'b1;
                div_state_next = frts_pkg::DIV_IDLE;
            end
        end

        // input register
        if (s_fire) begin
            in_valid_next = 1'b1;
            in_cmd_next   = s_tuser[0];
            in_epoch_next = s_tdata[EW-1:0];
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        // one item through the timer
        events   = '0;
        sec_ev   = 1'b0;
        tick_new = tick_reg;
        sec_new  = sec_cmp_reg;
        if (advance) begin
            if (in_cmd_reg == frts_pkg::CMD_SET_EPOCH) begin
                epoch_next = in_epoch_reg;
                sec_new    = tick_reg + frts_pkg::TICK_MOD;
            end else begin
                tick_new = tick_reg + 1'b1;
                for (int i = 0; i < NCH; i++) begin
                    chan_on = (value_reg[i] != '0) &&
                              (mode_reg[i] == frts_pkg::MODE_INTERVAL ||
                               mode_reg[i] == frts_pkg::MODE_RATE);
                    acc_sum = {1'b0, acc_reg[i]} + {1'b0, err_reg[i]};
                    period  = {1'b0, short_reg[i]};
                    if (chan_on && cmp_reg[i] == tick_new) begin
                        events[i] = 1'b1;
                        if (err_reg[i] != '0) begin
                            if (acc_sum >= {1'b0, rate_reg[i]}) begin
                                acc_next[i] = VW'(acc_sum - {1'b0, rate_reg[i]});
                                period      = {1'b0, short_reg[i]} + 1'b1;
                            end else begin
                                acc_next[i] = acc_sum[VW-1:0];
                            end
                        end
                        cmp_next[i] = CW'(SMW'(cmp_reg[i]) + SMW'(period));
                    end
                end
                if (sec_cmp_reg == tick_new) begin
                    sec_ev     = 1'b1;
                    epoch_next = epoch_reg + 1'b1;
                    sec_new    = sec_cmp_reg + frts_pkg::TICK_MOD;
                end
            end
            tick_next    = tick_new;
            sec_cmp_next = sec_new;
        end

        // sub-second ticks from the post-item counter and compare
        sub_full = frts_pkg::TICK_MOD + tick_new - sec_new;

        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = M_DATA_W_L'({sub_full[frts_pkg::SUB_W-1:0],
                                          epoch_next, sec_ev, events});
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCH; i++) begin
                mode_reg[i]  <= frts_pkg::MODE_OFF;
                value_reg[i] <= VW'(1);
                cmp_reg[i]   <= CW'(1);
                acc_reg[i]   <= '0;
                short_reg[i] <= SW'(1);
                err_reg[i]   <= '0;
                rate_reg[i]  <= VW'(1);
            end
            pend_reg      <= '0;
            div_state_reg <= frts_pkg::DIV_IDLE;
            tick_reg      <= '0;
            sec_cmp_reg   <= frts_pkg::TICK_MOD;
            epoch_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            value_reg     <= value_next;
            cmp_reg       <= cmp_next;
            acc_reg       <= acc_next;
            short_reg     <= short_next;
            err_reg       <= err_next;
            rate_reg      <= rate_next;
            pend_reg      <= pend_next;
            div_state_reg <= div_state_next;
            tick_reg      <= tick_next;
            sec_cmp_reg   <= sec_cmp_next;
            epoch_reg     <= epoch_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        div_chan_reg <= div_chan_next;
        div_r_reg    <= div_r_next;
        div_q_reg    <= div_q_next;
        div_rem_reg  <= div_rem_next;
        div_cnt_reg  <= div_cnt_next;
        in_cmd_reg   <= in_cmd_next;
        in_epoch_reg <= in_epoch_next;
        out_data_reg <= out_data_next;
    end

endmodule

### verif/fractional_rate_tick_scheduler_test.sv
// Self-checking testbench for the fractional-rate tick scheduler, with a predictor and random traffic.
module fractional_rate_tick_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;

    // register map: mode and value of each channel interleaved
    localparam logic [frts_pkg::CFG_ADDR_W-1:0] REG_CH0_MODE  = frts_pkg::CFG_ADDR_W'(0);
    localparam logic [frts_pkg::CFG_ADDR_W-1:0] REG_CH0_VALUE = frts_pkg::CFG_ADDR_W'(1);
    localparam int                              REG_STRIDE    = 2;
    localparam logic [frts_pkg::CFG_ADDR_W-1:0] REG_SPARE_LO  = frts_pkg::CFG_ADDR_LAST + 1'b1;
    localparam logic [frts_pkg::CFG_ADDR_W-1:0] REG_SPARE_HI  = '1;

    // the one mode code with no meaning, read as off
    localparam logic [frts_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic        command;
        logic [31:0] epoch_value;
    } tick_item_t;

    // same order as m_tdata, channel events in the lowest bits
    typedef struct packed {
        logic [frts_pkg::SUB_W-1:0]   sub_ticks;
        logic [frts_pkg::EPOCH_W-1:0] epoch;
        logic                         second;
        logic [frts_pkg::NUM_CH-1:0]  events;
    } sched_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [frts_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic [frts_pkg::S_USER_W-1:0]   s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [frts_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            cfg_wr_en = 1'b0;
    logic [frts_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [frts_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    fractional_rate_tick_scheduler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    tick_item_t    pending_items[$];
    sched_result_t expected_reports[$];
    int            mismatches = 0;
    bit            s_accepted = 1'b0;
    int            gap_left = 0;
    int            burst_left = 0;
    bit            hold_request = 1'b0;
    int            hold_left = 0;
    int            pattern_left = 0;
    logic [15:0]   stall_pattern = '1;
    int            quiet_cycles = 0;

    // predictor state
    logic [frts_pkg::MODE_W-1:0]  ch_mode [frts_pkg::NUM_CH];
    logic [frts_pkg::VAL_W-1:0]   ch_value[frts_pkg::NUM_CH];
    bit                           ch_on   [frts_pkg::NUM_CH];
    logic [frts_pkg::CNT_W-1:0]   ch_cmp  [frts_pkg::NUM_CH];
    int unsigned                  ch_acc  [frts_pkg::NUM_CH];
    int unsigned                  ch_short[frts_pkg::NUM_CH];
    int unsigned                  ch_err  [frts_pkg::NUM_CH];
    int unsigned                  ch_rate [frts_pkg::NUM_CH];
    logic [frts_pkg::CNT_W-1:0]   tick_cnt;
    logic [frts_pkg::CNT_W-1:0]   sec_cmp;
    logic [frts_pkg::EPOCH_W-1:0] epoch_cnt;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // re-derive periods of one channel and restart it from the current count
    task automatic derive_chan(input int n);
        int unsigned v;
        int unsigned r;
        v = ch_value[n];
        ch_on[n] = (v != 0) && (ch_mode[n] == frts_pkg::MODE_INTERVAL ||
                                ch_mode[n] == frts_pkg::MODE_RATE);
        if (v == 0) begin
            ch_short[n] = 1;
            ch_err[n]   = 0;
            ch_rate[n]  = 1;
        end else if (ch_mode[n] == frts_pkg::MODE_RATE) begin
            r = (v > frts_pkg::TICK_RATE) ? frts_pkg::TICK_RATE : v;
            ch_rate[n]  = r;
            ch_short[n] = frts_pkg::TICK_RATE / r;
            ch_err[n]   = frts_pkg::TICK_RATE - ch_short[n] * r;
        end else begin
            ch_short[n] = v;
            ch_err[n]   = 0;
            ch_rate[n]  = frts_pkg::TICK_RATE / v;
        end
        ch_acc[n] = 0;
        ch_cmp[n] = tick_cnt + frts_pkg::CNT_W'(ch_short[n]);
    endtask

    task automatic reset_schedule();
        int n;
        tick_cnt  = '0;
        sec_cmp   = frts_pkg::TICK_MOD;
        epoch_cnt = '0;
        for (n = 0; n < frts_pkg::NUM_CH; n++) begin
            ch_mode[n]  = frts_pkg::MODE_OFF;
            ch_value[n] = 1;
            derive_chan(n);
        end
    endtask

    task automatic apply_reg(input logic [frts_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [frts_pkg::CFG_DATA_W-1:0] data);
        int n;
        if (idx <= frts_pkg::CFG_ADDR_LAST) begin
            n = idx / REG_STRIDE;
            if (idx % REG_STRIDE == REG_CH0_MODE)
                ch_mode[n] = data[frts_pkg::MODE_W-1:0];
            else
                ch_value[n] = data;
            derive_chan(n);
        end
    endtask

    task automatic step_schedule(input logic cmd, input logic [31:0] new_epoch,
                                 output sched_result_t r);
        int                         n;
        int unsigned                period;
        logic [frts_pkg::CNT_W-1:0] phase;
        r = '0;
        if (cmd == frts_pkg::CMD_SET_EPOCH) begin
            epoch_cnt = new_epoch;
            sec_cmp   = tick_cnt + frts_pkg::TICK_MOD;
        end else begin
            tick_cnt = tick_cnt + 1'b1;
            for (n = 0; n < frts_pkg::NUM_CH; n++) begin
                if (ch_on[n] && ch_cmp[n] == tick_cnt) begin
                    period = ch_short[n];
                    // Bresenham: carry the remainder, stretch by one tick on overflow
                    if (ch_err[n] != 0) begin
                        ch_acc[n] += ch_err[n];
                        if (ch_acc[n] >= ch_rate[n]) begin
                            ch_acc[n] -= ch_rate[n];
                            period++;
                        end
                    end
                    ch_cmp[n] = ch_cmp[n] + frts_pkg::CNT_W'(period);
                    r.events[n] = 1'b1;
                end
            end
            if (sec_cmp == tick_cnt) begin
                epoch_cnt = epoch_cnt + 1'b1;
                sec_cmp   = sec_cmp + frts_pkg::TICK_MOD;
                r.second  = 1'b1;
            end
        end
        phase       = frts_pkg::TICK_MOD + tick_cnt - sec_cmp;
        r.epoch     = epoch_cnt;
        r.sub_ticks = phase[frts_pkg::SUB_W-1:0];
    endtask

    // monitor, predictor feed and watchdog
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        bit            moved;
        s_accepted = 1'b0;
        moved = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                got = m_tdata[frts_pkg::M_FIELDS_W-1:0];
                if (expected_reports.size() == 0) begin
                    report_mismatch($sformatf("result %h with no item outstanding", got));
                end else begin
                    want = expected_reports.pop_front();
                    if (got.events !== want.events)
                        report_mismatch($sformatf("channel_events %h, expected %h",
                                                  got.events, want.events));
                    if (got.second !== want.second)
                        report_mismatch($sformatf("second_event %b, expected %b",
                                                  got.second, want.second));
                    if (got.epoch !== want.epoch)
                        report_mismatch($sformatf("epoch_seconds %h, expected %h",
                                                  got.epoch, want.epoch));
                    if (got.sub_ticks !== want.sub_ticks)
                        report_mismatch($sformatf("sub_second_ticks %0d, expected %0d",
                                                  got.sub_ticks, want.sub_ticks));
                end
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                s_accepted = 1'b1;
                step_schedule(s_tuser[0], s_tdata, want);
                expected_reports.push_back(want);
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // sender: bursts of items separated by random gaps
    always @(negedge aclk) begin
        tick_item_t it;
        if (!s_tvalid || s_accepted) begin
            if (gap_left != 0 || pending_items.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end else begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.command;
                s_tdata  <= it.epoch_value;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: rotating stall pattern, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left  = 64;
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end else begin
                pattern_left--;
            end
            m_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    task automatic push_item(input logic cmd, input logic [31:0] val);
        tick_item_t it;
        it.command     = cmd;
        it.epoch_value = val;
        pending_items.push_back(it);
    endtask

    task automatic push_ticks(input int count);
        int i;
        for (i = 0; i < count; i++)
            push_item(frts_pkg::CMD_TICK, $urandom);
    endtask

    task automatic push_random_items(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 8)
                push_item(frts_pkg::CMD_SET_EPOCH,
                          ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : 32'($urandom));
            else
                push_item(frts_pkg::CMD_TICK, $urandom);
        end
    endtask

    // everything sent, every result back
    task automatic wait_idle();
        @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge aclk);
    endtask

    // only called when idle; a rate write keeps s_tready low while it divides
    task automatic write_reg(input logic [frts_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [frts_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        apply_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic set_channel(input int n, input logic [frts_pkg::MODE_W-1:0] mode,
                               input logic [frts_pkg::VAL_W-1:0] value);
        write_reg(frts_pkg::CFG_ADDR_W'(REG_CH0_MODE + REG_STRIDE * n), {14'($urandom), mode});
        write_reg(frts_pkg::CFG_ADDR_W'(REG_CH0_VALUE + REG_STRIDE * n), value);
    endtask

    task automatic randomise_channels();
        int                          n;
        logic [frts_pkg::MODE_W-1:0] mode;
        logic [frts_pkg::VAL_W-1:0]  value;
        for (n = 0; n < frts_pkg::NUM_CH; n++) begin
            mode = $urandom_range(0, 9) < 4 ? frts_pkg::MODE_INTERVAL :
                   ($urandom_range(0, 5) == 0 ? frts_pkg::MODE_W'($urandom)
                                              : frts_pkg::MODE_RATE);
            case ($urandom_range(0, 9))
                0: value = 0;
                1: value = 1;
                2: value = 16'hFFFF;
                3: value = 16'($urandom);
                4: value = 16'($urandom_range(frts_pkg::TICK_RATE + 1, 65535));
                default:
                    // keep periods short so channels fire often
                    value = (mode == frts_pkg::MODE_INTERVAL)
                            ? 16'($urandom_range(1, 12))
                            : 16'($urandom_range(2000, frts_pkg::TICK_RATE));
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(frts_pkg::CFG_ADDR_W'(REG_CH0_VALUE + REG_STRIDE * n), value);
                write_reg(frts_pkg::CFG_ADDR_W'(REG_CH0_MODE + REG_STRIDE * n),
                          {14'($urandom), mode});
            end else begin
                set_channel(n, mode, value);
            end
        end
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
    endtask

    initial begin
        int phase;
        reset_schedule();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all channels off: ticks and epoch loads
        push_item(frts_pkg::CMD_TICK, 32'h0);
        push_item(frts_pkg::CMD_TICK, 32'hFFFF_FFFF);
        push_item(frts_pkg::CMD_SET_EPOCH, 32'hFFFF_FFFF);
        push_item(frts_pkg::CMD_TICK, 32'h0);
        push_item(frts_pkg::CMD_SET_EPOCH, 32'h0);
        push_item(frts_pkg::CMD_SET_EPOCH, 32'h5555_5555);
        push_item(frts_pkg::CMD_TICK, 32'h0);
        push_item(frts_pkg::CMD_SET_EPOCH, 32'hAAAA_AAAA);
        wait_idle();

        // every tick, saturated rate, fractional rate
        set_channel(0, frts_pkg::MODE_INTERVAL, 1);
        set_channel(1, frts_pkg::MODE_RATE, 16'hFFFF);
        set_channel(2, frts_pkg::MODE_RATE, 9000);
        push_ticks(4);
        push_item(frts_pkg::CMD_SET_EPOCH, 32'h0000_0001);
        push_ticks(4);
        wait_idle();

        // unused mode, zero value, exact tick rate, writes to missing registers
        write_reg(REG_CH0_MODE, {14'h3FFF, MODE_SPARE});
        set_channel(1, frts_pkg::MODE_INTERVAL, 0);
        set_channel(2, frts_pkg::MODE_RATE, frts_pkg::VAL_W'(frts_pkg::TICK_RATE));
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        push_ticks(6);
        wait_idle();

        for (phase = 0; phase < 8; phase++) begin
            randomise_channels();
            if (phase == 2)
                hold_request = 1'b1;
            push_random_items(180);
            wait_idle();
        end

        // slow rates and the longest interval, epoch loaded at its top value
        set_channel(0, frts_pkg::MODE_RATE, 1);
        set_channel(1, frts_pkg::MODE_RATE, 7);
        set_channel(2, frts_pkg::MODE_INTERVAL, 16'hFFFF);
        push_item(frts_pkg::CMD_SET_EPOCH, 32'hFFFF_FFFF);
        push_ticks(40);
        push_item(frts_pkg::CMD_SET_EPOCH, $urandom);
        push_ticks(32);
        wait_idle();

        repeat (8) @(posedge aclk);
        if (expected_reports.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
